FILE: hw/rtl/sitda_pkg.sv
// sitda_pkg: shared types, constants and tables for the signed integer to
// decimal ascii converter. No dependencies; used by every rtl file of the block.

package sitda_pkg;

  // field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 8;

  // decimal places of a 32-bit magnitude and the counter that walks them
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int unsigned DIGIT_W = 4;

  // weights j * 10^k reach 9e9, which needs 34 bits
  localparam int unsigned WEIGHT_W = 34;

  // character codes
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [NUM_DIGITS-1:0][WEIGHT_W-1:0] weight_tbl_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic emit_sign;
    logic step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_neg;
    logic out_free;
    logic last_pos;
  } status_t;

  // table of mult * 10^k for every decimal place k, built at elaboration
  function automatic weight_tbl_t weight_table(input int unsigned mult);
    weight_tbl_t     tbl;
    longint unsigned pw;
    pw = 64'd1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      tbl[k] = weight_t'(pw * longint'(mult));
      pw     = pw * 64'd10;
    end
    return tbl;
  endfunction

endpackage

FILE: hw/rtl/sitda_ctrl.sv
// sitda_ctrl: sequencer for the converter, drives load, sign and digit
// commands to sitda_datapath. Depends on sitda_pkg.

module sitda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sitda_pkg::status_t status_i,
  output sitda_pkg::cmd_t    cmd_o
);

  sitda_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      sitda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_pos) begin
            state_d = sitda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sitda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/sitda_datapath.sv
// sitda_datapath: magnitude register, digit extraction one place per cycle
// while output is free, and output character register. Depends on sitda_pkg.

module sitda_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [sitda_pkg::VALUE_W-1:0]    value_i,
  input  sitda_pkg::cmd_t                  cmd_i,
  output sitda_pkg::status_t               status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sitda_pkg::CHAR_W-1:0]     out_char_o,
  output logic                             out_last_o
);

  localparam int unsigned VW = sitda_pkg::VALUE_W;
  localparam int unsigned WW = sitda_pkg::WEIGHT_W;
  localparam int unsigned IW = sitda_pkg::DIGIT_IDX_W;
  localparam int unsigned DW = sitda_pkg::DIGIT_W;

  logic [VW-1:0]                  rem_q, rem_d;
  logic [IW-1:0]                  idx_q;
  logic                           started_q;
  logic                           out_valid_q;
  logic [sitda_pkg::CHAR_W-1:0]   char_q;
  logic                           last_q;

  logic [WW:0]                    diff [1:9];
  logic [9:1]                     ge;
  logic [DW-1:0]                  digit;
  logic                           last_pos;
  logic                           emit_digit;

  // trial subtraction of every multiple of the current place weight
  for (genvar j = 1; j <= 9; j++) begin : g_trial
    localparam sitda_pkg::weight_tbl_t WTBL = sitda_pkg::weight_table(j);
    assign diff[j] = {1'b0, {(WW-VW){1'b0}}, rem_q} - {1'b0, WTBL[idx_q]};
    assign ge[j]   = ~diff[j][WW];
  end

  // largest multiple that fits gives the digit and the new remainder
  always_comb begin
    digit = '0;
    rem_d = rem_q;
    for (int j = 1; j <= 9; j++) begin
      if (ge[j]) begin
        digit = DW'(j);
        rem_d = diff[j][VW-1:0];
      end
    end
  end

  assign last_pos   = (idx_q == '0);
  // leading zeros are dropped, but the units place always prints
  assign emit_digit = cmd_i.step && ((digit != '0) || started_q || last_pos);

  // magnitude and place counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i[VW-1] ? (VW'(0) - value_i) : value_i;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q     <= IW'(sitda_pkg::NUM_DIGITS - 1);
      started_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q     <= idx_q - IW'(1);
      started_q <= started_q | emit_digit;
    end
  end

  // output character register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= sitda_pkg::ASCII_MINUS;
      last_q <= 1'b0;
    end else if (emit_digit) begin
      char_q <= sitda_pkg::ASCII_ZERO + {{(sitda_pkg::CHAR_W-DW){1'b0}}, digit};
      last_q <= last_pos;
    end
  end

  // output valid, cleared once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.in_neg   = value_i[VW-1];
  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign status_o.last_pos = last_pos;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_top.sv
// signed_int_to_decimal_ascii_top: stream wrapper joining sitda_ctrl and
// sitda_datapath. Depends on sitda_pkg, sitda_ctrl and sitda_datapath.

// Converts one 32-bit two's-complement integer per input transaction into its
// decimal text, one ASCII character per output transaction, most significant
// digit first, with a leading '-' for negative values and tlast on the final
// character. The digit sequencer resolves one decimal place per cycle while
// the output is free, with a bank of trial subtractions, leading zero places
// being skipped without output; output stalls hold it. A new value is taken
// only once the previous number's last character sits in the output register.

module signed_int_to_decimal_ascii_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sitda_pkg::VALUE_W-1:0] s_axis_tdata,   // [31:0] value
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sitda_pkg::CHAR_W-1:0]  m_axis_tdata,   // [7:0] ascii_char
  output logic                          m_axis_tlast    // last_char
);

  sitda_pkg::cmd_t    cmd;
  sitda_pkg::status_t status;

  // sequencer
  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // digit datapath and output register
  sitda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
